// ===== rtl/fapd_pkg.sv =====
`timescale 1ns / 1ps

package fapd_pkg;

    // Header bytes of a frame.
    localparam logic [7:0] HDR_FIRST  = 8'h50;  // 'P'
    localparam logic [7:0] HDR_SECOND = 8'h52;  // 'R'

    // Words at or above this base carry a negative magnitude.
    localparam int unsigned NEG_BASE = 10000;

    // Payload bytes that are kept: pitch low/high, roll low/high.
    localparam int unsigned ANGLE_BYTES = 4;

    // Depth of the frame queue between front and back.
    localparam int unsigned QDEPTH = 2;

    localparam int unsigned ANGLE_W = 17;

    typedef logic [ANGLE_BYTES-1:0][7:0] frame_t;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Little-endian word; words of NEG_BASE and above mean -(w - NEG_BASE).
    function automatic angle_t decode_word(logic [7:0] lo, logic [7:0] hi);
        logic [15:0]        w;
        logic [ANGLE_W-1:0] v;
        begin
            w = {hi, lo};
            if (w >= 16'(NEG_BASE))
            begin
                v = ANGLE_W'(NEG_BASE) - {1'b0, w};
            end
            else
            begin
                v = {1'b0, w};
            end
            return angle_t'(v);
        end
    endfunction

endpackage

// ===== rtl/fapd_front.sv =====
`timescale 1ns / 1ps

module fapd_front #(
    parameter int unsigned FRAME_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          rx_byte,
    input  fapd_pkg::q_status_t q_status,
    output logic                in_stall,
    output logic                push_valid,
    output fapd_pkg::frame_t    push_frame
);

    localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int unsigned IDX_W = $clog2(fapd_pkg::ANGLE_BYTES);

    typedef enum logic [1:0] {
        HUNT,
        GOT_P,
        PAYLOAD
    } phase_t;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    fapd_pkg::frame_t bytes_reg;
    fapd_pkg::frame_t bytes_next;
    logic             accept;
    logic             store;
    logic             last;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign last     = (count_reg == CNT_W'(FRAME_BYTES - 1));
    assign store    = accept && (phase_reg == PAYLOAD) && (rx_byte != fapd_pkg::HDR_FIRST);

    always_comb
    begin
        bytes_next = bytes_reg;
        if (count_reg < CNT_W'(fapd_pkg::ANGLE_BYTES))
        begin
            bytes_next[count_reg[IDX_W-1:0]] = rx_byte;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (rx_byte == fapd_pkg::HDR_FIRST)
            begin
                // restart the header, keep the count
                phase_next = GOT_P;
            end
            else
            begin
                unique case (phase_reg)
                    GOT_P:
                    begin
                        if (rx_byte == fapd_pkg::HDR_SECOND)
                        begin
                            phase_next = PAYLOAD;
                        end
                        else
                        begin
                            phase_next = HUNT;
                            count_next = '0;
                        end
                    end
                    PAYLOAD:
                    begin
                        if (last)
                        begin
                            phase_next = HUNT;
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        phase_next = HUNT;
                        count_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= HUNT;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            bytes_reg <= bytes_next;
        end
    end

    assign push_valid = store && last;
    assign push_frame = bytes_next;

endmodule

// ===== rtl/fapd_queue.sv =====
`timescale 1ns / 1ps

module fapd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  fapd_pkg::frame_t    push_frame,
    input  logic                pop,
    output fapd_pkg::frame_t    pop_frame,
    output fapd_pkg::q_status_t q_status
);

    localparam int unsigned PTR_W = (fapd_pkg::QDEPTH > 1) ? $clog2(fapd_pkg::QDEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(fapd_pkg::QDEPTH + 1);

    fapd_pkg::frame_t slots_reg [fapd_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        begin
            if (p == PTR_W'(fapd_pkg::QDEPTH - 1))
            begin
                return '0;
            end
            return p + PTR_W'(1);
        end
    endfunction

    assign q_status.full  = (fill_reg == CNT_W'(fapd_pkg::QDEPTH));
    assign q_status.empty = (fill_reg == '0);
    assign do_push        = push_valid && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_frame      = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// ===== rtl/fapd_back.sv =====
`timescale 1ns / 1ps

module fapd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  fapd_pkg::q_status_t q_status,
    input  fapd_pkg::frame_t    pop_frame,
    output logic                pop,
    input  logic                out_stall,
    output logic                out_valid,
    output fapd_pkg::angle_t    pitch_tenths,
    output fapd_pkg::angle_t    roll_tenths
);

    logic             valid_reg;
    fapd_pkg::angle_t pitch_reg;
    fapd_pkg::angle_t roll_reg;

    // advance when the output register is empty or being taken
    assign pop = !q_status.empty && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pitch_reg <= fapd_pkg::decode_word(pop_frame[0], pop_frame[1]);
            roll_reg  <= fapd_pkg::decode_word(pop_frame[2], pop_frame[3]);
        end
    end

    assign out_valid    = valid_reg;
    assign pitch_tenths = pitch_reg;
    assign roll_tenths  = roll_reg;

endmodule

// ===== rtl/framed_angle_packet_decoder_core.sv =====
`timescale 1ns / 1ps

// Framed angle packet decoder.
// Input channel: one received serial byte per word (rx_byte, in_valid/in_stall).
// The front hunts for the header 'P','R'; any 'P' restarts the header and any
// other unexpected byte drops the hunt. After the header FRAME_BYTES payload
// bytes are counted and the first four kept.
// Output channel: one word per completed frame (pitch_tenths, roll_tenths,
// out_valid/out_stall), each a signed 17-bit angle in tenths of a degree.
// Throughput: one byte per cycle while in_stall is low, set by the
// combinational header check in the front; a frame needs at least
// FRAME_BYTES + 2 bytes.
// Path: the frame enters the queue at the edge that accepted the last payload
// byte and is decoded into the output register of the back when the back pops
// it from the queue; out_valid rises with that register.
// Stall: a two-entry frame queue parts front and back. When the receiver
// stalls, the result holds in the output register, further frames pile into
// the queue, and in_stall rises only once the queue is full.
// Reset: rst_n clears the hunt, the payload count, the queue and out_valid;
// in_stall is low after reset, so the block can accept bytes at once.

module framed_angle_packet_decoder_core #(
    parameter int unsigned FRAME_BYTES = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              rx_byte,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [16:0]      pitch_tenths,
    output logic signed [16:0]      roll_tenths
);

    fapd_pkg::q_status_t q_status;
    logic                push_valid;
    fapd_pkg::frame_t    push_frame;
    fapd_pkg::frame_t    pop_frame;
    logic                pop;
    fapd_pkg::angle_t    pitch_w;
    fapd_pkg::angle_t    roll_w;

    // front: header hunt and payload store, pushes one frame per completion
    fapd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .rx_byte    (rx_byte),
        .q_status   (q_status),
        .in_stall   (in_stall),
        .push_valid (push_valid),
        .push_frame (push_frame)
    );

    // short frame queue between front and back
    fapd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .q_status   (q_status)
    );

    // back: decode both words into the registered output
    fapd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_frame    (pop_frame),
        .pop          (pop),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .pitch_tenths (pitch_w),
        .roll_tenths  (roll_w)
    );

    assign pitch_tenths = pitch_w;
    assign roll_tenths  = roll_w;

endmodule
